### hw/rtl/fpsc_pkg.sv
package fpsc_pkg;

  typedef enum logic [2:0] {
    CMD_POWER    = 3'd0,
    CMD_CHAN_ONE = 3'd1,
    CMD_CHAN_TWO = 3'd2,
    CMD_NEXT     = 3'd3,
    CMD_PREV     = 3'd4,
    CMD_TICK     = 3'd5
  } cmd_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_HOLD = 1'b0;
  localparam logic [15:0] HOLD_RESET = 16'd200;

  typedef struct packed {
    logic [5:0] led_lines;
    logic       amp_enable;
    logic       display_enable;
    logic [3:0] effect_code;
    logic [3:0] effect_number;
    logic       powered_flag;
    logic [1:0] blink_flags;
  } result_t;

  function automatic logic [3:0] effect_code_of(input logic [3:0] idx);
    logic [3:0] code;
    case (idx)
      4'd0: code = 4'd9;
      4'd1: code = 4'd13;
      4'd2: code = 4'd5;
      4'd3: code = 4'd1;
      4'd4: code = 4'd0;
      4'd5: code = 4'd4;
      4'd6: code = 4'd6;
      4'd7: code = 4'd2;
      4'd8: code = 4'd15;
      4'd9: code = 4'd11;
      4'd10: code = 4'd3;
      4'd11: code = 4'd10;
      4'd12: code = 4'd14;
      4'd13: code = 4'd7;
      4'd14: code = 4'd8;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  function automatic logic [5:0] pattern_one(input logic [1:0] src);
    logic [6:0] w;
    w = 7'd1 << src;
    return w[5:0];
  endfunction

  function automatic logic [5:0] pattern_two(input logic [1:0] src);
    logic [6:0] w;
    w = 7'd8 << src;
    return w[5:0];
  endfunction

  function automatic logic [5:0] steady_pattern(input logic [1:0] s1, input logic [1:0] s2);
    logic [6:0] sum;
    sum = {1'b0, pattern_one(s1)} + {1'b0, pattern_two(s2)};
    return sum[5:0];
  endfunction

endpackage

### hw/rtl/fpsc_cfg.sv
module fpsc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic [15:0]                       hold_threshold
);

  logic [15:0] hold_r;
  logic        hit;

  assign hit = (paddr[fpsc_pkg::CFG_ADDR_W-1] == fpsc_pkg::CFG_IDX_HOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= fpsc_pkg::HOLD_RESET;
    end else if (psel && penable && pwrite && hit) begin
      hold_r <= pwdata[15:0];
    end
  end

  assign prdata = hit ? {16'd0, hold_r} : 32'd0;
  assign hold_threshold = hold_r;

endmodule

### hw/rtl/fpsc_core.sv
module fpsc_core #(
  parameter int unsigned EFFECT_COUNT        = 15,
  parameter int unsigned SOURCES_PER_CHANNEL = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [2:0]          command,
  input  logic [15:0]         press_length,
  input  logic [15:0]         hold_threshold,
  output fpsc_pkg::result_t   result_nxt
);

  localparam logic [2:0] SRC_LIMIT = 3'(SOURCES_PER_CHANNEL);
  localparam logic [4:0] FX_LIMIT  = 5'(EFFECT_COUNT);
  localparam logic [3:0] FX_LAST   = 4'(EFFECT_COUNT - 1);

  logic       is_on_r, is_on_nxt;
  logic [1:0] src_one_r, src_one_nxt;
  logic [1:0] src_two_r, src_two_nxt;
  logic [1:0] blink_r, blink_nxt;
  logic [3:0] fx_r, fx_nxt;
  logic [5:0] led_r, led_nxt;
  logic       amp_r, amp_nxt;
  logic       disp_r, disp_nxt;

  logic [1:0] ch_bit;
  logic [2:0] step_one, step_two;
  logic [4:0] fx_inc;

  always_comb begin
    ch_bit = (command == fpsc_pkg::CMD_CHAN_ONE) ? 2'b01 : 2'b10;
    step_one = {1'b0, src_one_r} + 3'd1;
    if (step_one >= SRC_LIMIT) step_one = 3'd0;
    step_two = {1'b0, src_two_r} + 3'd1;
    if (step_two >= SRC_LIMIT) step_two = 3'd0;
    fx_inc = {1'b0, fx_r} + 5'd1;

    is_on_nxt   = is_on_r;
    src_one_nxt = src_one_r;
    src_two_nxt = src_two_r;
    blink_nxt   = blink_r;
    fx_nxt      = fx_r;
    led_nxt     = led_r;
    amp_nxt     = amp_r;
    disp_nxt    = disp_r;

    case (fpsc_pkg::cmd_t'(command))
      fpsc_pkg::CMD_POWER: begin
        if (!is_on_r) begin
          is_on_nxt = 1'b1;
          amp_nxt   = 1'b1;
          disp_nxt  = 1'b1;
          fx_nxt    = 4'd0;
          led_nxt   = fpsc_pkg::steady_pattern(src_one_r, src_two_r);
        end else begin
          is_on_nxt   = 1'b0;
          amp_nxt     = 1'b0;
          disp_nxt    = 1'b0;
          led_nxt     = 6'd0;
          blink_nxt   = 2'd0;
          src_one_nxt = 2'd0;
          src_two_nxt = 2'd0;
        end
      end
      fpsc_pkg::CMD_CHAN_ONE, fpsc_pkg::CMD_CHAN_TWO: begin
        if (is_on_r) begin
          if ((blink_r & ch_bit) != 2'd0) begin
            if (press_length > hold_threshold) begin
              blink_nxt = blink_r & ~ch_bit;
              if ((blink_r & ~ch_bit) == 2'd0) amp_nxt = 1'b1;
            end else if (ch_bit[0]) begin
              src_one_nxt = step_one[1:0];
            end else begin
              src_two_nxt = step_two[1:0];
            end
            led_nxt = fpsc_pkg::steady_pattern(src_one_nxt, src_two_nxt);
          end else begin
            blink_nxt = blink_r | ch_bit;
            amp_nxt   = 1'b0;
          end
        end
      end
      fpsc_pkg::CMD_NEXT: begin
        if (is_on_r) begin
          fx_nxt = (fx_inc >= FX_LIMIT) ? 4'd0 : fx_inc[3:0];
        end
      end
      fpsc_pkg::CMD_PREV: begin
        if (is_on_r) begin
          if (fx_r == 4'd0 || {1'b0, fx_r} >= FX_LIMIT) fx_nxt = FX_LAST;
          else fx_nxt = fx_r - 4'd1;
        end
      end
      fpsc_pkg::CMD_TICK: begin
        led_nxt = led_r
                ^ (blink_r[0] ? fpsc_pkg::pattern_one(src_one_r) : 6'd0)
                ^ (blink_r[1] ? fpsc_pkg::pattern_two(src_two_r) : 6'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_on_r   <= 1'b0;
      src_one_r <= 2'd0;
      src_two_r <= 2'd0;
      blink_r   <= 2'd0;
      fx_r      <= 4'd0;
      led_r     <= 6'd0;
      amp_r     <= 1'b0;
      disp_r    <= 1'b0;
    end else if (step) begin
      is_on_r   <= is_on_nxt;
      src_one_r <= src_one_nxt;
      src_two_r <= src_two_nxt;
      blink_r   <= blink_nxt;
      fx_r      <= fx_nxt;
      led_r     <= led_nxt;
      amp_r     <= amp_nxt;
      disp_r    <= disp_nxt;
    end
  end

  always_comb begin
    result_nxt.led_lines      = led_nxt;
    result_nxt.amp_enable     = amp_nxt;
    result_nxt.display_enable = disp_nxt;
    result_nxt.effect_code    = fpsc_pkg::effect_code_of(fx_nxt);
    result_nxt.effect_number  = fx_nxt;
    result_nxt.powered_flag   = is_on_nxt;
    result_nxt.blink_flags    = blink_nxt;
  end

endmodule

### hw/rtl/front_panel_selector_controller.sv
// channel  | handshake                         | payload
// in       | in_valid / in_ready               | in_command, in_press_length
// out      | out_valid / out_ready             | out_led_lines .. out_blink_flags
// cfg      | cfg_psel, cfg_penable, cfg_pwrite | cfg_paddr, cfg_pwdata, cfg_prdata
//
// One item per cycle sustained while out_ready stays high.
// The panel state updates as an item moves from the input register to the result register.
// rst_n is synchronous: state, hold threshold (200) and both valid flags clear.
// A stalled result holds; the input register still takes one more item behind it.
module front_panel_selector_controller #(
  parameter int unsigned EFFECT_COUNT        = 15,
  parameter int unsigned SOURCES_PER_CHANNEL = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_command,
  input  logic [15:0]                     in_press_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      out_led_lines,
  output logic                            out_amp_enable,
  output logic                            out_display_enable,
  output logic [3:0]                      out_effect_code,
  output logic [3:0]                      out_effect_number,
  output logic                            out_powered_flag,
  output logic [1:0]                      out_blink_flags,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fpsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic              in_valid_r;
  logic [2:0]        cmd_r;
  logic [15:0]       len_r;
  logic              out_valid_r;
  fpsc_pkg::result_t res_r;
  fpsc_pkg::result_t res_nxt;
  logic [15:0]       hold_threshold;
  logic              advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  fpsc_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .hold_threshold (hold_threshold)
  );
  assign cfg_pready = 1'b1;

  fpsc_core #(
    .EFFECT_COUNT        (EFFECT_COUNT),
    .SOURCES_PER_CHANNEL (SOURCES_PER_CHANNEL)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .command        (cmd_r),
    .press_length   (len_r),
    .hold_threshold (hold_threshold),
    .result_nxt     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      len_r <= in_press_length;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_led_lines      = res_r.led_lines;
  assign out_amp_enable     = res_r.amp_enable;
  assign out_display_enable = res_r.display_enable;
  assign out_effect_code    = res_r.effect_code;
  assign out_effect_number  = res_r.effect_number;
  assign out_powered_flag   = res_r.powered_flag;
  assign out_blink_flags    = res_r.blink_flags;

endmodule

### hw/rtl/fpsc_checker.sv
module fpsc_checker #(
  parameter int unsigned EFFECT_COUNT = 15
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_led_lines,
  input logic       out_amp_enable,
  input logic       out_display_enable,
  input logic [3:0] out_effect_number,
  input logic       out_powered_flag,
  input logic [1:0] out_blink_flags
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_lines)
      && $stable(out_effect_number) && $stable(out_blink_flags))
    else $error("result changed while stalled");

  a_display_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_display_enable == out_powered_flag)
    else $error("display line differs from power state");

  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_powered_flag |-> !out_amp_enable && out_blink_flags == 2'd0
      && out_led_lines == 6'd0)
    else $error("panel lines active while off");

  a_amp_blink: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_amp_enable |-> out_blink_flags == 2'd0)
    else $error("amplifier on while a channel blinks");

  a_fx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_effect_number} < 5'(EFFECT_COUNT))
    else $error("effect index out of range");

endmodule

bind front_panel_selector_controller fpsc_checker #(
  .EFFECT_COUNT (EFFECT_COUNT)
) u_fpsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_led_lines      (out_led_lines),
  .out_amp_enable     (out_amp_enable),
  .out_display_enable (out_display_enable),
  .out_effect_number  (out_effect_number),
  .out_powered_flag   (out_powered_flag),
  .out_blink_flags    (out_blink_flags)
);

### sim/tb_front_panel_selector_controller.sv
`timescale 1ns / 1ps

module tb_front_panel_selector_controller;

  localparam int unsigned FX_COUNT = 15;
  localparam int unsigned SRC_COUNT = 3;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [fpsc_pkg::CFG_ADDR_W-1:0] HOLD_ADDR = {fpsc_pkg::CFG_IDX_HOLD, 2'b00};
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned ITEMS_PER_PHASE = 255;

  localparam logic [3:0] FX_CODE [16] = '{
    4'd9, 4'd13, 4'd5, 4'd1, 4'd0, 4'd4, 4'd6, 4'd2,
    4'd15, 4'd11, 4'd3, 4'd10, 4'd14, 4'd7, 4'd8, 4'd0
  };

  typedef struct {
    logic       powered;
    logic [1:0] src_one;
    logic [1:0] src_two;
    logic [1:0] blink;
    logic [3:0] fx;
    logic [5:0] leds;
    logic       amp;
    logic       disp;
  } panel_t;

  typedef struct {
    logic [2:0]        cmd;
    logic [15:0]       len;
    bit                typed;
    fpsc_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [15:0] in_press_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_led_lines;
  logic        out_amp_enable;
  logic        out_display_enable;
  logic [3:0]  out_effect_code;
  logic [3:0]  out_effect_number;
  logic        out_powered_flag;
  logic [1:0]  out_blink_flags;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [fpsc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  panel_t            pnl;
  logic [15:0]       hold_lvl;
  fpsc_pkg::result_t lines_due [$];
  stim_row_t         dir_tab [$];
  int                err_count = 0;
  int                tx_idle_pct = 29;
  int                rx_idle_pct = 54;
  bit                long_hold_go = 1'b0;
  int unsigned       cycles = 0;

  front_panel_selector_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_press_length    (in_press_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_led_lines      (out_led_lines),
    .out_amp_enable     (out_amp_enable),
    .out_display_enable (out_display_enable),
    .out_effect_code    (out_effect_code),
    .out_effect_number  (out_effect_number),
    .out_powered_flag   (out_powered_flag),
    .out_blink_flags    (out_blink_flags),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("front_panel_selector_controller test failed");
      $finish;
    end
  end

  function automatic logic [5:0] leds_one(input logic [1:0] s);
    logic [5:0] v;
    v = 6'd1 << s;
    return v;
  endfunction

  function automatic logic [5:0] leds_two(input logic [1:0] s);
    logic [5:0] v;
    v = 6'd8 << s;
    return v;
  endfunction

  function automatic logic [1:0] next_source(input logic [1:0] s);
    int unsigned n;
    n = s + 1;
    if (n >= SRC_COUNT) n = 0;
    return n[1:0];
  endfunction

  function automatic fpsc_pkg::result_t advance_panel(input logic [2:0] cmd,
                                                      input logic [15:0] len);
    fpsc_pkg::result_t r;
    int                ch;
    case (cmd)
      fpsc_pkg::CMD_POWER: begin
        if (!pnl.powered) begin
          pnl.powered = 1'b1;
          pnl.amp = 1'b1;
          pnl.disp = 1'b1;
          pnl.fx = '0;
          pnl.leds = leds_one(pnl.src_one) + leds_two(pnl.src_two);
        end else begin
          pnl.powered = 1'b0;
          pnl.amp = 1'b0;
          pnl.disp = 1'b0;
          pnl.leds = '0;
          pnl.blink = '0;
          pnl.src_one = '0;
          pnl.src_two = '0;
        end
      end
      fpsc_pkg::CMD_TICK: begin
        if (pnl.blink[0]) pnl.leds = pnl.leds ^ leds_one(pnl.src_one);
        if (pnl.blink[1]) pnl.leds = pnl.leds ^ leds_two(pnl.src_two);
      end
      fpsc_pkg::CMD_CHAN_ONE, fpsc_pkg::CMD_CHAN_TWO: begin
        if (pnl.powered) begin
          ch = (cmd == fpsc_pkg::CMD_CHAN_ONE) ? 0 : 1;
          if (pnl.blink[ch]) begin
            if (len > hold_lvl) begin
              pnl.blink[ch] = 1'b0;
              if (pnl.blink == 2'b00) pnl.amp = 1'b1;
            end else if (ch == 0) begin
              pnl.src_one = next_source(pnl.src_one);
            end else begin
              pnl.src_two = next_source(pnl.src_two);
            end
            pnl.leds = leds_one(pnl.src_one) + leds_two(pnl.src_two);
          end else begin
            pnl.blink[ch] = 1'b1;
            pnl.amp = 1'b0;
          end
        end
      end
      fpsc_pkg::CMD_NEXT: begin
        if (pnl.powered) pnl.fx = (pnl.fx + 1 >= FX_COUNT) ? 4'd0 : pnl.fx + 4'd1;
      end
      fpsc_pkg::CMD_PREV: begin
        if (pnl.powered) begin
          if (pnl.fx == 0 || pnl.fx >= FX_COUNT) pnl.fx = 4'(FX_COUNT - 1);
          else pnl.fx = pnl.fx - 4'd1;
        end
      end
      default: ;
    endcase
    r.led_lines = pnl.leds;
    r.amp_enable = pnl.amp;
    r.display_enable = pnl.disp;
    r.effect_code = FX_CODE[pnl.fx];
    r.effect_number = pnl.fx;
    r.powered_flag = pnl.powered;
    r.blink_flags = pnl.blink;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : rx_side
    fpsc_pkg::result_t got;
    fpsc_pkg::result_t want;
    int                hold_left;
    bit                hold_seen;
    if (rst_n && out_valid && out_ready) begin
      got = {out_led_lines, out_amp_enable, out_display_enable, out_effect_code,
             out_effect_number, out_powered_flag, out_blink_flags};
      if (lines_due.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, got);
        err_count++;
      end else begin
        want = lines_due.pop_front();
        check_field("led_lines", want.led_lines, got.led_lines);
        check_field("amp_enable", want.amp_enable, got.amp_enable);
        check_field("display_enable", want.display_enable, got.display_enable);
        check_field("effect_code", want.effect_code, got.effect_code);
        check_field("effect_number", want.effect_number, got.effect_number);
        check_field("powered_flag", want.powered_flag, got.powered_flag);
        check_field("blink_flags", want.blink_flags, got.blink_flags);
      end
    end
    if (long_hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_item(input logic [2:0] cmd, input logic [15:0] len,
                           input bit typed, input fpsc_pkg::result_t want);
    fpsc_pkg::result_t pred;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_press_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = advance_panel(cmd, len);
    lines_due.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(input logic [15:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= HOLD_ADDR;
    cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    hold_lvl = val;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin tx_idle_pct = 29; rx_idle_pct = 54; end
      1: begin tx_idle_pct = 54; rx_idle_pct = 29; end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
  endtask

  initial begin
    logic [15:0] hold_set [6];
    logic [2:0]  cmd;
    logic [15:0] len;
    int          r;
    pnl = '{default: '0};
    hold_lvl = fpsc_pkg::HOLD_RESET;
    hold_set = '{16'd0, 16'hFFFF, 16'($urandom_range(65535)), 16'd1,
                 16'($urandom_range(1000)), 16'd200};

    // off: everything ignored but the effect code
    dir_tab.push_back('{fpsc_pkg::CMD_TICK, 16'd0, 1'b1,
                        {6'd0, 1'b0, 1'b0, 4'd9, 4'd0, 1'b0, 2'd0}});
    dir_tab.push_back('{fpsc_pkg::CMD_NEXT, 16'd0, 1'b1,
                        {6'd0, 1'b0, 1'b0, 4'd9, 4'd0, 1'b0, 2'd0}});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_ONE, 16'd0, 1'b1,
                        {6'd0, 1'b0, 1'b0, 4'd9, 4'd0, 1'b0, 2'd0}});
    dir_tab.push_back('{CMD_SPARE_A, 16'd0, 1'b1, {6'd0, 1'b0, 1'b0, 4'd9, 4'd0, 1'b0, 2'd0}});
    dir_tab.push_back('{CMD_SPARE_B, 16'hFFFF, 1'b1,
                        {6'd0, 1'b0, 1'b0, 4'd9, 4'd0, 1'b0, 2'd0}});
    dir_tab.push_back('{fpsc_pkg::CMD_POWER, 16'd0, 1'b1,
                        {6'd9, 1'b1, 1'b1, 4'd9, 4'd0, 1'b1, 2'd0}});
    // prev wraps 0 -> 14
    dir_tab.push_back('{fpsc_pkg::CMD_PREV, 16'd0, 1'b1,
                        {6'd9, 1'b1, 1'b1, 4'd8, 4'd14, 1'b1, 2'd0}});
    dir_tab.push_back('{fpsc_pkg::CMD_NEXT, 16'd0, 1'b1,
                        {6'd9, 1'b1, 1'b1, 4'd9, 4'd0, 1'b1, 2'd0}});
    dir_tab.push_back('{fpsc_pkg::CMD_PREV, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_NEXT, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_NEXT, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_ONE, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_TICK, 16'd0, 1'b0, '0});
    // press equal to threshold is short
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_ONE, 16'd200, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_ONE, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_ONE, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_TWO, 16'hFFFF, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_TICK, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_TWO, 16'hFFFF, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_ONE, 16'd201, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_TWO, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_CHAN_TWO, 16'd0, 1'b0, '0});
    // power off keeps the effect index
    dir_tab.push_back('{fpsc_pkg::CMD_POWER, 16'd0, 1'b1,
                        {6'd0, 1'b0, 1'b0, 4'd13, 4'd1, 1'b0, 2'd0}});
    dir_tab.push_back('{fpsc_pkg::CMD_TICK, 16'd0, 1'b0, '0});
    dir_tab.push_back('{fpsc_pkg::CMD_POWER, 16'd0, 1'b1,
                        {6'd9, 1'b1, 1'b1, 4'd9, 4'd0, 1'b1, 2'd0}});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(0);
    foreach (dir_tab[i]) push_item(dir_tab[i].cmd, dir_tab[i].len, dir_tab[i].typed,
                                   dir_tab[i].want);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_hold(hold_set[p]);
      set_idle(p / 2);
      if (p == 4) long_hold_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 5 && n == ITEMS_PER_PHASE / 2) wait_drained();
        r = $urandom_range(99);
        if (!pnl.powered) begin
          cmd = (r < 60) ? fpsc_pkg::CMD_POWER : 3'($urandom_range(7));
        end else if (r < 4) cmd = fpsc_pkg::CMD_POWER;
        else if (r < 40) cmd = fpsc_pkg::CMD_CHAN_ONE;
        else if (r < 70) cmd = fpsc_pkg::CMD_CHAN_TWO;
        else if (r < 78) cmd = fpsc_pkg::CMD_NEXT;
        else if (r < 86) cmd = fpsc_pkg::CMD_PREV;
        else if (r < 97) cmd = fpsc_pkg::CMD_TICK;
        else cmd = r[0] ? CMD_SPARE_A : CMD_SPARE_B;
        case ($urandom_range(5))
          0: len = 16'd0;
          1: len = 16'hFFFF;
          2: len = hold_lvl;
          3: len = hold_lvl + 16'd1;
          4: len = hold_lvl - 16'd1;
          default: len = 16'($urandom_range(65535));
        endcase
        push_item(cmd, len, 1'b0, '0);
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("front_panel_selector_controller test passed");
    end else begin
      $display("front_panel_selector_controller test failed");
    end
    $finish;
  end

endmodule
